/* sv/bbait_pkg.sv */
package bbait_pkg;

	typedef enum logic [1:0] {
		OP_CREATE = 2'd0,
		OP_DELETE = 2'd1,
		OP_LOOKUP = 2'd2,
		OP_LIST   = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_SPACE  = 3'd1,
		ST_NO_INODE  = 3'd2,
		ST_TOO_LARGE = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_BAD_INDEX = 3'd5,
		ST_EMPTY     = 3'd6
	} status_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [63:0] name_hi;
		logic [63:0] name_lo;
		logic [3:0]  size_in_blocks;
		logic [3:0]  block_index;
	} req_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [3:0]  inode_index;
		logic [6:0]  block_address;
		logic [63:0] listed_name_hi;
		logic [63:0] listed_name_lo;
		logic [3:0]  listed_size;
		logic        last;
	} rsp_t;

endpackage

/* sv/bbait_if.sv */
interface bbait_req_if;
	logic valid;
	logic ready;
	bbait_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface bbait_rsp_if;
	logic valid;
	logic ready;
	bbait_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* sv/bitmap_block_allocator_inode_table.sv */
// Create scans the bitmap one block a cycle; a too-large create is rejected without a scan.
//   Delete and lookup scan the inodes in order; delete then frees each block of the inode.
// List: the scan waits on output stalls.
// Throughput: one transaction at a time; the next is taken only after the last result is accepted.
// Reset: asynchronous, active low; the bitmap is cleared by a pass over all NUM_BLOCKS blocks
//   after reset, during which no transaction is accepted. Inode valid bits clear at once.
module bitmap_block_allocator_inode_table #(
	parameter int NUM_BLOCKS     = 128,
	parameter int NUM_INODES     = 16,
	parameter int PTRS_PER_INODE = 8
) (
	input logic clk,
	input logic arst_n,
	bbait_req_if.sink   req,
	bbait_rsp_if.source rsp
);
	localparam int BW = $clog2(NUM_BLOCKS);
	localparam int IW = (NUM_INODES > 1) ? $clog2(NUM_INODES) : 1;
	localparam int PW = (PTRS_PER_INODE > 1) ? $clog2(PTRS_PER_INODE) : 1;
	localparam int CW = $clog2(NUM_BLOCKS + 1);

	typedef enum logic [10:0] {
		S_CLEAR   = 11'b00000000001,
		S_IDLE    = 11'b00000000010,
		S_ISCAN   = 11'b00000000100,
		S_IRD     = 11'b00000001000,
		S_ALLOC   = 11'b00000010000,
		S_FREE    = 11'b00000100000,
		S_LKRD    = 11'b00001000000,
		S_LKDAT   = 11'b00010000000,
		S_LIST    = 11'b00100000000,
		S_LISTRD  = 11'b01000000000,
		S_OUT     = 11'b10000000000
	} state_t;

	state_t state_q;
	bbait_pkg::req_t req_q;
	logic [NUM_INODES-1:0] valid_q;
	logic [CW-1:0] free_cnt_q;
	logic [BW-1:0] bptr_q;
	logic [IW-1:0] ino_q, iptr_q;
	logic [4:0] k_q;
	logic found_q, any_q, pending_q;
	bbait_pkg::rsp_t rsp_q;
	logic rsp_valid_q;

	// memories
	logic bitmap_mem [NUM_BLOCKS];
	logic bitmap_rd;
	logic [63:0] nh_mem [NUM_INODES];
	logic [63:0] nl_mem [NUM_INODES];
	logic [3:0]  cnt_mem [NUM_INODES];
	logic [63:0] nh_rd, nl_rd;
	logic [3:0]  cnt_rd;
	logic [BW-1:0] ptr_mem [2**(IW+PW)];
	logic [BW-1:0] ptr_rd;

	logic bm_we, bm_wd;
	logic [BW-1:0] bm_wa, bm_ra;
	logic in_we;
	logic [IW-1:0] in_a;
	logic pt_we;
	logic [IW+PW-1:0] pt_a;

	// bitmap scan is one step behind the address: bptr_q addresses, read comes next cycle
	logic [BW-1:0] rd_blk_q;
	logic rd_ok_q;

	bbait_pkg::rsp_t list_rsp;

	wire idle_ok = (state_q == S_IDLE) && !pending_q;
	assign req.ready = idle_ok;
	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_q;

	wire name_eq = (nh_rd == req_q.name_hi) && (nl_rd == req_q.name_lo);
	wire [PW-1:0] kp = k_q[PW-1:0];

	always_comb begin
		bm_ra = bptr_q;
		pt_a = {ino_q, kp};
		if (state_q == S_LKRD)
			pt_a = {ino_q, req_q.block_index[PW-1:0]};
		in_a = iptr_q;
	end

	always_ff @(posedge clk) begin
		bitmap_rd <= bitmap_mem[bm_ra];
		if (bm_we) bitmap_mem[bm_wa] <= bm_wd;
	end

	always_ff @(posedge clk) begin
		nh_rd <= nh_mem[in_a];
		nl_rd <= nl_mem[in_a];
		cnt_rd <= cnt_mem[in_a];
		if (in_we) begin
			nh_mem[ino_q] <= req_q.name_hi;
			nl_mem[ino_q] <= req_q.name_lo;
			cnt_mem[ino_q] <= req_q.size_in_blocks;
		end
	end

	always_ff @(posedge clk) begin
		ptr_rd <= ptr_mem[pt_a];
		if (pt_we) ptr_mem[pt_a] <= rd_blk_q;
	end

	logic [IW-1:0] first_free;
	logic has_free;
	always_comb begin
		first_free = '0;
		has_free = 1'b0;
		for (int i = NUM_INODES - 1; i >= 0; i--)
			if (!valid_q[i]) begin
				first_free = IW'(i);
				has_free = 1'b1;
			end
	end

	// list entry for the inode at iptr_q; last when no valid inode follows
	always_comb begin
		list_rsp = '0;
		list_rsp.status = bbait_pkg::ST_OK;
		list_rsp.inode_index = 4'(iptr_q);
		list_rsp.listed_name_hi = nh_rd;
		list_rsp.listed_name_lo = nl_rd;
		list_rsp.listed_size = cnt_rd;
		list_rsp.last = 1'b1;
		for (int i = 0; i < NUM_INODES; i++)
			if (i > int'(iptr_q) && valid_q[i]) list_rsp.last = 1'b0;
	end

	function automatic bbait_pkg::rsp_t emit(input bbait_pkg::status_t st,
			input logic [IW-1:0] ino, input logic [BW-1:0] addr, input logic lst);
		bbait_pkg::rsp_t r;
		r = '0;
		r.status = st;
		r.inode_index = 4'(ino);
		r.block_address = 7'(addr);
		r.last = lst;
		return r;
	endfunction

	always_comb begin
		bm_we = 1'b0; bm_wd = 1'b0; bm_wa = bptr_q;
		in_we = 1'b0; pt_we = 1'b0;
		if (state_q == S_CLEAR) begin
			bm_we = 1'b1;
		end else if (state_q == S_ALLOC && rd_ok_q && !bitmap_rd &&
				k_q < 5'(req_q.size_in_blocks)) begin
			bm_we = 1'b1; bm_wd = 1'b1; bm_wa = rd_blk_q; pt_we = 1'b1;
		end else if (state_q == S_FREE && rd_ok_q) begin
			bm_we = 1'b1; bm_wa = ptr_rd;
		end
		if (state_q == S_IRD && req_q.op == bbait_pkg::OP_CREATE) in_we = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			valid_q <= '0;
			free_cnt_q <= CW'(NUM_BLOCKS);
			bptr_q <= '0;
			rsp_valid_q <= 1'b0;
			pending_q <= 1'b0;
			rd_ok_q <= 1'b0;
			k_q <= '0;
			found_q <= 1'b0;
			any_q <= 1'b0;
			iptr_q <= '0;
			ino_q <= '0;
		end else begin
			if (rsp.valid && rsp.ready) rsp_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					bptr_q <= bptr_q + 1'b1;
					if (bptr_q == BW'(NUM_BLOCKS - 1)) state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (pending_q && !rsp_valid_q) pending_q <= 1'b0;
					if (req.valid && idle_ok) begin
						req_q <= req.data;
						iptr_q <= '0;
						k_q <= '0;
						found_q <= 1'b0;
						any_q <= 1'b0;
						rd_ok_q <= 1'b0;
						bptr_q <= '0;
						pending_q <= 1'b1;
						unique case (bbait_pkg::op_t'(req.data.op))
							bbait_pkg::OP_CREATE: begin
								if ({1'b0, req.data.size_in_blocks} > 5'(PTRS_PER_INODE))
									state_q <= S_OUT;
								else state_q <= S_ISCAN;
								rsp_q <= emit(bbait_pkg::ST_TOO_LARGE, '0, '0, 1'b1);
							end
							bbait_pkg::OP_LIST: state_q <= S_LIST;
							default: state_q <= S_ISCAN;
						endcase
					end
				end
				S_ISCAN: begin
					if (req_q.op == bbait_pkg::OP_CREATE) begin
						if (free_cnt_q < CW'(req_q.size_in_blocks)) begin
							rsp_q <= emit(bbait_pkg::ST_NO_SPACE, '0, '0, 1'b1);
							state_q <= S_OUT;
						end else if (!has_free) begin
							rsp_q <= emit(bbait_pkg::ST_NO_INODE, '0, '0, 1'b1);
							state_q <= S_OUT;
						end else begin
							ino_q <= first_free;
							state_q <= S_IRD;
						end
					end else begin
						state_q <= S_IRD;
					end
				end
				S_IRD: begin
					// for delete/lookup: iptr_q addressed last cycle, data valid now
					if (req_q.op == bbait_pkg::OP_CREATE) begin
						valid_q[ino_q] <= 1'b1;
						free_cnt_q <= free_cnt_q - CW'(req_q.size_in_blocks);
						rsp_q <= emit(bbait_pkg::ST_OK, ino_q, '0, 1'b1);
						if (req_q.size_in_blocks == 4'd0) state_q <= S_OUT;
						else begin
							bptr_q <= bptr_q + 1'b1;
							rd_blk_q <= bptr_q;
							rd_ok_q <= 1'b1;
							state_q <= S_ALLOC;
						end
					end else if (!found_q) begin
						if (valid_q[iptr_q] && name_eq) begin
							found_q <= 1'b1;
							ino_q <= iptr_q;
						end else if (iptr_q == IW'(NUM_INODES - 1)) begin
							rsp_q <= emit(bbait_pkg::ST_NOT_FOUND, '0, '0, 1'b1);
							state_q <= S_OUT;
						end else begin
							iptr_q <= iptr_q + 1'b1;
							state_q <= S_ISCAN;
						end
					end else begin
						// cnt_rd is for ino_q
						if (req_q.op == bbait_pkg::OP_DELETE) begin
							valid_q[ino_q] <= 1'b0;
							rsp_q <= emit(bbait_pkg::ST_OK, ino_q, '0, 1'b1);
							if (cnt_rd == 4'd0) state_q <= S_OUT;
							else begin
								req_q.size_in_blocks <= cnt_rd;
								state_q <= S_FREE;
							end
						end else if ({1'b0, req_q.block_index} >= {1'b0, cnt_rd} ||
								{1'b0, req_q.block_index} >= 5'(PTRS_PER_INODE)) begin
							rsp_q <= emit(bbait_pkg::ST_BAD_INDEX, ino_q, '0, 1'b1);
							state_q <= S_OUT;
						end else state_q <= S_LKRD;
					end
				end
				S_ALLOC: begin
					if (rd_ok_q && !bitmap_rd) k_q <= k_q + 1'b1;
					if (rd_ok_q && !bitmap_rd &&
							k_q + 1'b1 == 5'(req_q.size_in_blocks)) begin
						rd_ok_q <= 1'b0;
						state_q <= S_OUT;
					end else begin
						rd_blk_q <= bptr_q;
						bptr_q <= bptr_q + 1'b1;
						rd_ok_q <= 1'b1;
					end
				end
				S_FREE: begin
					// pointer read at k_q issued; data next cycle
					if (rd_ok_q) free_cnt_q <= free_cnt_q + 1'b1;
					if (rd_ok_q && k_q == 5'(req_q.size_in_blocks)) begin
						rd_ok_q <= 1'b0;
						state_q <= S_OUT;
					end else if (k_q == 5'(req_q.size_in_blocks)) begin
						rd_ok_q <= 1'b0;
					end else begin
						rd_ok_q <= 1'b1;
						k_q <= k_q + 1'b1;
					end
				end
				S_LKRD: state_q <= S_LKDAT;
				S_LKDAT: begin
					rsp_q <= emit(bbait_pkg::ST_OK, ino_q, ptr_rd, 1'b1);
					state_q <= S_OUT;
				end
				S_LIST: begin
					if (!rsp_valid_q || (rsp.valid && rsp.ready)) begin
						if (!valid_q[iptr_q] && iptr_q != IW'(NUM_INODES - 1))
							iptr_q <= iptr_q + 1'b1;
						else state_q <= S_LISTRD;
					end
				end
				S_LISTRD: begin
					if (valid_q[iptr_q]) begin
						rsp_q <= list_rsp;
						rsp_valid_q <= 1'b1;
						any_q <= 1'b1;
					end else if (!any_q) begin
						rsp_q <= emit(bbait_pkg::ST_EMPTY, '0, '0, 1'b1);
						rsp_valid_q <= 1'b1;
					end
					if (iptr_q == IW'(NUM_INODES - 1)) state_q <= S_IDLE;
					else begin
						iptr_q <= iptr_q + 1'b1;
						state_q <= S_LIST;
					end
				end
				S_OUT: begin
					rsp_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* sv/bbait_checker.sv */
module bbait_checker (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	input logic req_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input logic [2:0] status,
	input logic [3:0] inode_index,
	input logic last
);
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(status))
		else $error("result changed while stalled");
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> !req_ready)
		else $error("request taken while result pending");
	a_err_zero_ino: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == bbait_pkg::ST_NO_SPACE || status == bbait_pkg::ST_NO_INODE ||
		status == bbait_pkg::ST_TOO_LARGE || status == bbait_pkg::ST_NOT_FOUND ||
		status == bbait_pkg::ST_EMPTY) |-> inode_index == 4'd0)
		else $error("inode index on error");
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != bbait_pkg::ST_OK |-> last)
		else $error("error result not last");
	a_ready_gap: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("two requests back to back");
endmodule

bind bitmap_block_allocator_inode_table bbait_checker u_chk (
	.clk(clk), .arst_n(arst_n),
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.status(rsp.data.status), .inode_index(rsp.data.inode_index),
	.last(rsp.data.last)
);
